[hdl/dpsfm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dpsfm_pkg;

    localparam int unsigned CNT_W  = 12;
    localparam int unsigned REC_W  = 8;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned TOL_W  = 7;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned CFG_W  = 12;
    localparam int unsigned SUM_W  = 10;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [REC_W-1:0] REC_MAX = '1;

    // fixed out-of-range limits and nominal channel sum
    localparam logic [POS_W-1:0] RANGE_LO    = 8'd9;
    localparam logic [POS_W-1:0] RANGE_HI    = 8'd91;
    localparam logic [SUM_W-1:0] SUM_NOMINAL = 10'd100;

    // register defaults
    localparam logic [CNT_W-1:0] FAULT_TICKS_RST   = 12'd600;
    localparam logic [REC_W-1:0] RECOVER_TICKS_RST = 8'd10;
    localparam logic [POS_W-1:0] SHORT_LEVEL_RST   = 8'd99;
    localparam logic [POS_W-1:0] OPEN_LEVEL_RST    = 8'd1;
    localparam logic [POS_W-1:0] WINDOW_LOW_RST    = 8'd10;
    localparam logic [POS_W-1:0] WINDOW_HIGH_RST   = 8'd90;
    localparam logic [TOL_W-1:0] SUM_TOL_RST       = 7'd3;

    typedef enum logic [IDX_W-1:0] {
        CFG_FAULT_TICKS   = 3'd0,
        CFG_RECOVER_TICKS = 3'd1,
        CFG_SHORT_LEVEL   = 3'd2,
        CFG_OPEN_LEVEL    = 3'd3,
        CFG_WINDOW_LOW    = 3'd4,
        CFG_WINDOW_HIGH   = 3'd5,
        CFG_SUM_TOL       = 3'd6
    } t_cfg_idx;

    // one per-channel monitor: two debounce counters, recovery counter, flag
    typedef struct packed {
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
        logic [REC_W-1:0] rec;
        logic             flag;
    } t_chan_st;

    // result flags, highest bit first when packed into tdata
    typedef struct packed {
        logic output_fault;
        logic data_fault_report;
        logic data_fault;
        logic open_fault;
        logic short_fault;
    } t_flags;

    function automatic logic [CNT_W-1:0] bump_cnt(input logic [CNT_W-1:0] c);
        bump_cnt = (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [REC_W-1:0] bump_rec(input logic [REC_W-1:0] c);
        bump_rec = (c == REC_MAX) ? c : c + 1'b1;
    endfunction

    // one tick of a per-channel monitor
    function automatic t_chan_st chan_step(
        input logic             cond_a,
        input logic             cond_b,
        input logic             good,
        input t_chan_st         cur,
        input logic [CNT_W-1:0] fault_ticks,
        input logic [REC_W-1:0] recover_ticks
    );
        t_chan_st nxt;
        logic     set;
        logic     flag;
        nxt = cur;
        set = 1'b0;
        if (!cond_a) begin
            nxt.cnt_a = '0;
        end else if (cur.cnt_a > fault_ticks) begin
            set = 1'b1;
        end else begin
            nxt.cnt_a = bump_cnt(cur.cnt_a);
        end
        if (!cond_b) begin
            nxt.cnt_b = '0;
        end else if (cur.cnt_b > fault_ticks) begin
            set = 1'b1;
        end else begin
            nxt.cnt_b = bump_cnt(cur.cnt_b);
        end
        // recovery sees the flag as just updated
        flag = cur.flag | set;
        if (flag && good) begin
            if (cur.rec > recover_ticks) begin
                nxt.rec = '0;
                flag    = 1'b0;
            end else begin
                nxt.rec = bump_rec(cur.rec);
            end
        end else begin
            nxt.rec = '0;
        end
        nxt.flag = flag;
        chan_step = nxt;
    endfunction

endpackage

`default_nettype wire

[hdl/dual_position_sensor_fault_monitor_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// an accepted item passes the input register, then the flag/result register; throughput:
// one item per cycle while the result side is not stalled, the counter update is a
// single pass of compares and saturating increments between the two registers
// reset (synchronous, active low): registers return to their defaults, all counters
// and fault flags clear, both stream sides empty

module dual_position_sensor_fault_monitor_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [7:0] pos_a, [15:8] pos_b
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [0] short_fault, [1] open_fault,
                                               // [2] data_fault, [3] data_fault_report,
                                               // [4] output_fault, [7:5] zero
    // register writes
    input  wire logic        i_cfg_we,
    input  wire logic [dpsfm_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [dpsfm_pkg::CFG_W-1:0] i_cfg_data
);

    // configuration registers
    logic [dpsfm_pkg::CNT_W-1:0] r_fault_ticks;
    logic [dpsfm_pkg::REC_W-1:0] r_recover_ticks;
    logic [dpsfm_pkg::POS_W-1:0] r_short_level;
    logic [dpsfm_pkg::POS_W-1:0] r_open_level;
    logic [dpsfm_pkg::POS_W-1:0] r_window_low;
    logic [dpsfm_pkg::POS_W-1:0] r_window_high;
    logic [dpsfm_pkg::TOL_W-1:0] r_sum_tol;

    // input register
    logic                        r_in_valid;
    logic [dpsfm_pkg::POS_W-1:0] r_pos_a;
    logic [dpsfm_pkg::POS_W-1:0] r_pos_b;

    // monitor state; the flags double as the result register
    dpsfm_pkg::t_chan_st         r_short, n_short;
    dpsfm_pkg::t_chan_st         r_open, n_open;
    dpsfm_pkg::t_chan_st         r_range, n_range;
    logic [dpsfm_pkg::CNT_W-1:0] r_sum_cnt, n_sum_cnt;
    logic [dpsfm_pkg::REC_W-1:0] r_sum_rec, n_sum_rec;
    logic                        r_data_flag, n_data_flag;
    logic                        r_data_rep, n_data_rep;
    logic                        r_out_valid;

    dpsfm_pkg::t_flags           flags;

    logic                        advance;
    logic                        good;
    logic [dpsfm_pkg::SUM_W-1:0] sum_ab;
    logic [dpsfm_pkg::SUM_W-1:0] tol_ext;
    logic                        sum_ok;

    // result stage moves when empty or drained; input stage refills behind it
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_ticks   <= dpsfm_pkg::FAULT_TICKS_RST;
            r_recover_ticks <= dpsfm_pkg::RECOVER_TICKS_RST;
            r_short_level   <= dpsfm_pkg::SHORT_LEVEL_RST;
            r_open_level    <= dpsfm_pkg::OPEN_LEVEL_RST;
            r_window_low    <= dpsfm_pkg::WINDOW_LOW_RST;
            r_window_high   <= dpsfm_pkg::WINDOW_HIGH_RST;
            r_sum_tol       <= dpsfm_pkg::SUM_TOL_RST;
        end else if (i_cfg_we) begin
            case (dpsfm_pkg::t_cfg_idx'(i_cfg_idx))
                dpsfm_pkg::CFG_FAULT_TICKS:   r_fault_ticks   <= i_cfg_data;
                dpsfm_pkg::CFG_RECOVER_TICKS: r_recover_ticks <= i_cfg_data[7:0];
                dpsfm_pkg::CFG_SHORT_LEVEL:   r_short_level   <= i_cfg_data[7:0];
                dpsfm_pkg::CFG_OPEN_LEVEL:    r_open_level    <= i_cfg_data[7:0];
                dpsfm_pkg::CFG_WINDOW_LOW:    r_window_low    <= i_cfg_data[7:0];
                dpsfm_pkg::CFG_WINDOW_HIGH:   r_window_high   <= i_cfg_data[7:0];
                dpsfm_pkg::CFG_SUM_TOL:       r_sum_tol       <= i_cfg_data[6:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_pos_a <= i_s_axis_tdata[7:0];
            r_pos_b <= i_s_axis_tdata[15:8];
        end
    end

    // both readings inside the healthy window
    assign good = (r_pos_a >= r_window_low) && (r_pos_a <= r_window_high) &&
                  (r_pos_b >= r_window_low) && (r_pos_b <= r_window_high);

    // -tol <= a + b - 100 < tol, kept unsigned by moving the terms across
    assign sum_ab  = {2'b00, r_pos_a} + {2'b00, r_pos_b};
    assign tol_ext = {3'b000, r_sum_tol};
    assign sum_ok  = (sum_ab + tol_ext >= dpsfm_pkg::SUM_NOMINAL) &&
                     (sum_ab < dpsfm_pkg::SUM_NOMINAL + tol_ext);

    always_comb begin
        n_short = dpsfm_pkg::chan_step(r_pos_a >= r_short_level, r_pos_b >= r_short_level,
                                       good, r_short, r_fault_ticks, r_recover_ticks);
        n_open  = dpsfm_pkg::chan_step(r_pos_a <= r_open_level, r_pos_b <= r_open_level,
                                       good, r_open, r_fault_ticks, r_recover_ticks);
        n_range = dpsfm_pkg::chan_step(
            (r_pos_a > dpsfm_pkg::RANGE_HI) || (r_pos_a < dpsfm_pkg::RANGE_LO),
            (r_pos_b > dpsfm_pkg::RANGE_HI) || (r_pos_b < dpsfm_pkg::RANGE_LO),
            good, r_range, r_fault_ticks, r_recover_ticks);

        // data monitor: recovery clears the flag but leaves the report
        n_sum_cnt   = r_sum_cnt;
        n_sum_rec   = r_sum_rec;
        n_data_flag = r_data_flag;
        n_data_rep  = r_data_rep;
        if (sum_ok) begin
            n_sum_cnt = '0;
            if (r_data_flag) begin
                if (r_sum_rec > r_recover_ticks) begin
                    n_data_flag = 1'b0;
                    n_sum_rec   = '0;
                end else begin
                    n_sum_rec = dpsfm_pkg::bump_rec(r_sum_rec);
                end
            end
        end else begin
            if (r_sum_cnt > r_fault_ticks) begin
                n_data_flag = 1'b1;
                n_data_rep  = 1'b1;
            end else begin
                // still counting: both flag and report drop
                n_data_flag = 1'b0;
                n_data_rep  = 1'b0;
                n_sum_cnt   = dpsfm_pkg::bump_cnt(r_sum_cnt);
            end
            n_sum_rec = '0;
        end
    end

    // monitor state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short     <= '0;
            r_open      <= '0;
            r_range     <= '0;
            r_sum_cnt   <= '0;
            r_sum_rec   <= '0;
            r_data_flag <= 1'b0;
            r_data_rep  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_short     <= n_short;
                r_open      <= n_open;
                r_range     <= n_range;
                r_sum_cnt   <= n_sum_cnt;
                r_sum_rec   <= n_sum_rec;
                r_data_flag <= n_data_flag;
                r_data_rep  <= n_data_rep;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        flags.short_fault       = r_short.flag;
        flags.open_fault        = r_open.flag;
        flags.data_fault        = r_data_flag;
        flags.data_fault_report = r_data_rep;
        flags.output_fault      = r_range.flag;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, flags};

`ifndef SYNTHESIS
    // the report only ever sets together with the data flag
    a_rep_with_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_data_rep) |-> r_data_flag)
        else $error("data report set without data flag");

    // monitor state moves only with an item
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(flags) && $stable(r_sum_cnt) && $stable(r_short.cnt_a))
        else $error("monitor state changed without an item");

    // full input stage behind a stalled result blocks new items
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while both stages full");

    // a result only appears after an item sat in the input register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an item");
`endif

endmodule

`default_nettype wire
